/* hw/rtl/fpcs_pkg.sv */
// Shared constants and register codes for the field peak-center smoother.
`default_nettype none
package fpcs_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int TICK_W          = 32;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRACKING_ENABLE = 1'b0
  } reg_idx_t;

endpackage
`default_nettype wire

/* hw/rtl/fpcs_if.sv */
// Request channels of the field peak-center smoother: tick input and result output.
`default_nettype none
interface fpcs_in_if #(
  parameter int SAMPLE_BITS = fpcs_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   read_ok;

  modport source (output valid, output sample, output read_ok, input ready);
  modport sink   (input valid, input sample, input read_ok, output ready);
endinterface

interface fpcs_out_if #(
  parameter int SAMPLE_BITS = fpcs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fpcs_pkg::FRAC_BITS_DEF
);
  localparam int FILT_W  = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int LEVEL_W = SAMPLE_BITS + 1;

  logic                            valid;
  logic                            ready;
  logic signed [FILT_W-1:0]        filtered_field;
  logic [LEVEL_W-1:0]              center_level;
  logic signed [LEVEL_W-1:0]       peak_max;
  logic [LEVEL_W-1:0]              peak_min;
  logic                            filter_loaded;
  logic [fpcs_pkg::TICK_W-1:0]     elapsed_ticks;

  modport source (output valid, output filtered_field, output center_level,
                  output peak_max, output peak_min, output filter_loaded,
                  output elapsed_ticks, input ready);
  modport sink   (input valid, input filtered_field, input center_level,
                  input peak_max, input peak_min, input filter_loaded,
                  input elapsed_ticks, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fpcs_regs.sv */
// APB-style configuration register file (tracking enable).
`default_nettype none
module fpcs_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fpcs_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [fpcs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [fpcs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output logic                                 tracking_enable
);

  fpcs_pkg::reg_idx_t reg_idx;
  logic               wr_en;
  logic               tracking_r;
  logic               tracking_nxt;

  assign reg_idx = fpcs_pkg::reg_idx_t'(paddr[fpcs_pkg::CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    tracking_nxt = tracking_r;
    prdata       = '0;
    unique case (reg_idx)
      fpcs_pkg::REG_TRACKING_ENABLE: begin
        prdata[0] = tracking_r;
        if (wr_en) begin
          tracking_nxt = pwdata[0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r <= 1'b0;
    end else begin
      tracking_r <= tracking_nxt;
    end
  end

  assign tracking_enable = tracking_r;

endmodule
`default_nettype wire

/* hw/rtl/field_peak_center_smoother.sv */
// Field peak-center smoother: min/max center removal and 3/4 exponential smoothing.
// A request goes through the input register, then the state/result registers; the state
// update is a single pass between them. Throughput: one request per cycle unless stalled.
// Results are the state registers themselves; they hold while the output is stalled.
// Reset (rst_n, synchronous): filter 0, not loaded, max -1, min 2^SAMPLE_BITS, center 0,
// tick count 0, tracking off, both channels empty.
`default_nettype none
module field_peak_center_smoother #(
  parameter int SAMPLE_BITS = fpcs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fpcs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fpcs_in_if.sink                              in_ch,
  fpcs_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fpcs_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [fpcs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [fpcs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  localparam int FILT_W  = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int LEVEL_W = SAMPLE_BITS + 1;
  localparam int DIFF_W  = SAMPLE_BITS + 2;
  localparam int ACC_W   = FILT_W + 2;

  logic tracking_enable;

  fpcs_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .tracking_enable (tracking_enable)
  );

  // input stage
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   s1_ok_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   in_fire;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_ch.sample;
      s1_ok_r     <= in_ch.read_ok;
    end
  end

  // field state, doubles as the result register
  logic signed [FILT_W-1:0]      filt_r,    filt_nxt;
  logic                          loaded_r,  loaded_nxt;
  logic signed [LEVEL_W-1:0]     max_r,     max_nxt;
  logic [LEVEL_W-1:0]            min_r,     min_nxt;
  logic [LEVEL_W-1:0]            center_r,  center_nxt;
  logic [fpcs_pkg::TICK_W-1:0]   tick_r,    tick_nxt;

  logic signed [LEVEL_W-1:0]     sample_s;
  logic signed [LEVEL_W-1:0]     max_upd;
  logic [LEVEL_W-1:0]            min_upd;
  logic [LEVEL_W:0]              center_sum;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [FILT_W-1:0]      x_val;
  logic signed [ACC_W-1:0]       filt_ext;
  logic signed [ACC_W-1:0]       x_ext;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_q;

  always_comb begin
    sample_s = $signed({1'b0, s1_sample_r});
    max_upd  = (sample_s > max_r) ? sample_s : max_r;
    min_upd  = ({1'b0, s1_sample_r} < min_r) ? {1'b0, s1_sample_r} : min_r;
    // the updated max is never negative, since it is at least the zero-extended sample
    center_sum = {max_upd[LEVEL_W-1], max_upd} + {1'b0, min_upd};

    max_nxt    = max_r;
    min_nxt    = min_r;
    center_nxt = center_r;
    filt_nxt   = filt_r;
    loaded_nxt = loaded_r;
    tick_nxt   = tick_r + fpcs_pkg::TICK_W'(1);

    if (s1_ok_r) begin
      if (tracking_enable) begin
        max_nxt    = max_upd;
        min_nxt    = min_upd;
        center_nxt = center_sum[LEVEL_W-1:0];
      end else begin
        max_nxt = '1;
        min_nxt = LEVEL_W'(1) << SAMPLE_BITS;
      end
    end

    // offset in half counts, scaled to FRAC_BITS fractional bits
    diff  = $signed({1'b0, s1_sample_r, 1'b0}) - $signed({1'b0, center_nxt});
    x_val = $signed({diff, {(FRAC_BITS-1){1'b0}}});

    filt_ext = {{2{filt_r[FILT_W-1]}}, filt_r};
    x_ext    = {{2{x_val[FILT_W-1]}}, x_val};
    acc      = (filt_ext <<< 1) + filt_ext + x_ext;
    acc_q    = acc >>> 2;

    if (s1_ok_r) begin
      loaded_nxt = 1'b1;
      filt_nxt   = loaded_r ? acc_q[FILT_W-1:0] : x_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      filt_r      <= '0;
      loaded_r    <= 1'b0;
      max_r       <= '1;
      min_r       <= LEVEL_W'(1) << SAMPLE_BITS;
      center_r    <= '0;
      tick_r      <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        filt_r      <= filt_nxt;
        loaded_r    <= loaded_nxt;
        max_r       <= max_nxt;
        min_r       <= min_nxt;
        center_r    <= center_nxt;
        tick_r      <= tick_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_field = filt_r;
  assign out_ch.center_level   = center_r;
  assign out_ch.peak_max       = max_r;
  assign out_ch.peak_min       = min_r;
  assign out_ch.filter_loaded  = loaded_r;
  assign out_ch.elapsed_ticks  = tick_r;

endmodule
`default_nettype wire
